// ===== design/lrd_pkg.sv =====
package lrd_pkg;

   localparam int FLOW_W = 24;
   localparam int COEF_W = 16;
   localparam logic [FLOW_W-1:0] FLOW_MAX = 24'hFFFFFF;
   localparam logic [FLOW_W-1:0] LIMIT_RESET = 24'd410;

   // face coefficients of one layer
   typedef struct packed {
      logic [COEF_W-1:0] bot_t;
      logic [COEF_W-1:0] bot_r;
      logic [COEF_W-1:0] bot_a;
      logic [COEF_W-1:0] top_t;
      logic [COEF_W-1:0] top_r;
      logic [COEF_W-1:0] top_a;
   } coef_row_type;

   // flows and absorbed sums of one layer
   typedef struct packed {
      logic [FLOW_W-1:0] abs_bot;
      logic [FLOW_W-1:0] abs_top;
      logic [FLOW_W-1:0] up;
      logic [FLOW_W-1:0] down;
   } flow_row_type;

   typedef struct packed {
      coef_row_type      coef;
      logic [FLOW_W-1:0] emit_down;
      logic [FLOW_W-1:0] emit_up;
      logic              last_layer;
   } layer_in_type;

   typedef struct packed {
      logic [3:0]        layer_number;
      logic [FLOW_W-1:0] absorbed_top;
      logic [FLOW_W-1:0] absorbed_bottom;
      logic [6:0]        iterations_used;
      logic              not_converged;
      logic              last_result;
   } result_type;

   function automatic logic [FLOW_W-1:0] sat_add(logic [FLOW_W-1:0] a, logic [FLOW_W-1:0] b);
      logic [FLOW_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FLOW_W] ? FLOW_MAX : s[FLOW_W-1:0];
   endfunction

endpackage

// ===== design/lrd_div.sv =====
// floor(num / den) saturated to 24 bits, one quotient bit per cycle
module lrd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] num,
   input  logic [32:0] den,
   output logic        done,
   output logic [23:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [23:0] rest_ff;
   logic [23:0] quot_ff;
   logic [32:0] rem2_in;
   logic [32:0] diff_in;
   logic        ge_in;
   logic        sat_in;

   assign sat_in  = {1'b0, num} >= {den, 24'd0};
   assign rem2_in = {rem_ff, rest_ff[23]};
   assign ge_in   = rem2_in >= den;
   assign diff_in = rem2_in - den;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (sat_in) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= lrd_pkg::FLOW_MAX;
         rem_ff  <= num[55:24];
         rest_ff <= num[23:0];
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[22:0], ge_in};
         rem_ff  <= ge_in ? diff_in[31:0] : rem2_in[31:0];
         rest_ff <= {rest_ff[22:0], 1'b0};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== design/lrd_core.sv =====
module lrd_core #(
   parameter int MAX_LAYERS = 16,
   parameter int MAX_SWEEPS = 99
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lrd_pkg::layer_in_type   in_item,
   input  logic [23:0]             residual_limit,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lrd_pkg::result_type     out_item
);

   localparam int IW  = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
   localparam int CW  = $clog2(MAX_LAYERS + 1);
   localparam int ITW = $clog2(MAX_SWEEPS + 1);
   localparam int RW  = lrd_pkg::FLOW_W + $clog2(2 * MAX_LAYERS);

   localparam logic [4:0] S_LOAD  = 5'd0;
   localparam logic [4:0] S_SWEEP = 5'd1;
   localparam logic [4:0] S_RD_S  = 5'd2;
   localparam logic [4:0] S_RD_D  = 5'd3;
   localparam logic [4:0] S_CAP_D = 5'd4;
   localparam logic [4:0] S_KMUL  = 5'd5;
   localparam logic [4:0] S_P1    = 5'd6;
   localparam logic [4:0] S_P2    = 5'd7;
   localparam logic [4:0] S_DIVS  = 5'd8;
   localparam logic [4:0] S_DIVW  = 5'd9;
   localparam logic [4:0] S_WR_S  = 5'd10;
   localparam logic [4:0] S_WR_D  = 5'd11;
   localparam logic [4:0] S_RS_A  = 5'd12;
   localparam logic [4:0] S_RS_B  = 5'd13;
   localparam logic [4:0] S_CHK   = 5'd14;
   localparam logic [4:0] S_FIN_A = 5'd15;
   localparam logic [4:0] S_FIN_B = 5'd16;
   localparam logic [4:0] S_FIN_W = 5'd17;
   localparam logic [4:0] S_OUT_A = 5'd18;
   localparam logic [4:0] S_OUT_B = 5'd19;

   localparam logic [1:0] T_DST_ABS  = 2'd0;
   localparam logic [1:0] T_DST_FLOW = 2'd1;
   localparam logic [1:0] T_SRC_ABS  = 2'd2;
   localparam logic [1:0] T_SRC_BACK = 2'd3;

   lrd_pkg::coef_row_type coef_mem [MAX_LAYERS];
   lrd_pkg::flow_row_type flow_mem [MAX_LAYERS];
   lrd_pkg::coef_row_type coef_rd_ff;
   lrd_pkg::flow_row_type flow_rd_ff;

   logic [4:0]     state_ff;
   logic [CW-1:0]  cnt_ff;
   logic [IW-1:0]  idx_ff;
   logic           dir_ff;        // 0: down sweep, 1: up sweep
   logic [ITW-1:0] iter_ff;
   logic [1:0]     t_ff;
   logic [32:0]    k_ff;
   logic [39:0]    p1_ff;
   logic [55:0]    num_ff;
   logic [RW-1:0]  res_ff;
   lrd_pkg::coef_row_type src_c_ff, dst_c_ff;
   lrd_pkg::flow_row_type src_f_ff, dst_f_ff;

   logic [IW-1:0]  dst_idx_in;
   logic [IW-1:0]  rd_addr_in;
   logic           flow_we_in;
   logic [IW-1:0]  flow_wa_in;
   lrd_pkg::flow_row_type flow_wd_in;
   logic           load_in;
   logic           room_in;
   logic [15:0]    a_d_in, t_d_in, r_d_in, a_s_in, t_s_in, r_s_in, coef_in;
   logic [23:0]    f_in;
   logic           div_done;
   logic [23:0]    div_q;
   logic [CW:0]    idx_p1_in;
   logic [CW:0]    idx_p2_in;
   logic [RW-1:0]  res_add_in;

   assign dst_idx_in = dir_ff ? idx_ff - IW'(1) : idx_ff + IW'(1);
   assign idx_p1_in  = (CW+1)'(idx_ff) + (CW+1)'(1);
   assign idx_p2_in  = (CW+1)'(idx_ff) + (CW+1)'(2);
   assign in_ready   = state_ff == S_LOAD;
   assign room_in    = cnt_ff != CW'(MAX_LAYERS);
   assign load_in    = in_valid && in_ready && room_in;

   // facing surfaces: down sweep uses dst top and src bottom, up sweep the reverse
   always_comb begin
      a_d_in = dir_ff ? dst_c_ff.bot_a : dst_c_ff.top_a;
      t_d_in = dir_ff ? dst_c_ff.bot_t : dst_c_ff.top_t;
      r_d_in = dir_ff ? dst_c_ff.bot_r : dst_c_ff.top_r;
      a_s_in = dir_ff ? src_c_ff.top_a : src_c_ff.bot_a;
      t_s_in = dir_ff ? src_c_ff.top_t : src_c_ff.bot_t;
      r_s_in = dir_ff ? src_c_ff.top_r : src_c_ff.bot_r;
      f_in   = dir_ff ? src_f_ff.up : src_f_ff.down;
      unique case (t_ff)
         T_DST_ABS:  coef_in = a_d_in;
         T_DST_FLOW: coef_in = t_d_in;
         T_SRC_ABS:  coef_in = a_s_in;
         default:    coef_in = t_s_in;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_RD_S:  rd_addr_in = idx_ff;
         S_RD_D:  rd_addr_in = dst_idx_in;
         S_FIN_A: rd_addr_in = '0;
         default: rd_addr_in = idx_ff;
      endcase
   end

   always_comb begin
      flow_we_in = 1'b0;
      flow_wa_in = idx_ff;
      flow_wd_in = src_f_ff;
      unique case (state_ff)
         S_LOAD: begin
            flow_we_in = load_in;
            flow_wa_in = cnt_ff[IW-1:0];
            flow_wd_in = '{abs_bot: '0, abs_top: '0, up: in_item.emit_up,
                           down: in_item.emit_down};
         end
         S_WR_S: begin
            flow_we_in = 1'b1;
            if (dir_ff) begin
               flow_wd_in.up = '0;
            end else begin
               flow_wd_in.down = '0;
            end
         end
         S_WR_D: begin
            flow_we_in = 1'b1;
            flow_wa_in = dst_idx_in;
            flow_wd_in = dst_f_ff;
         end
         S_FIN_W: begin
            flow_we_in = 1'b1;
            flow_wa_in = '0;
         end
         default: begin
            flow_we_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         coef_mem[cnt_ff[IW-1:0]] <= in_item.coef;
      end
      if (flow_we_in) begin
         flow_mem[flow_wa_in] <= flow_wd_in;
      end
      coef_rd_ff <= coef_mem[rd_addr_in];
      flow_rd_ff <= flow_mem[rd_addr_in];
   end

   lrd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DIVS),
      .num   (num_ff),
      .den   (k_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   assign res_add_in = (idx_ff == '0) ? RW'(flow_rd_ff.down)
                     : RW'(flow_rd_ff.down) + RW'(flow_rd_ff.up);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         dir_ff   <= 1'b0;
         iter_ff  <= '0;
         t_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (in_valid) begin
                  if (room_in) begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end
                  if (in_item.last_layer) begin
                     iter_ff  <= '0;
                     state_ff <= S_SWEEP;
                  end
               end
            end
            S_SWEEP: begin
               iter_ff <= iter_ff + ITW'(1);
               res_ff  <= '0;
               idx_ff  <= '0;
               dir_ff  <= 1'b0;
               state_ff <= (cnt_ff >= CW'(2)) ? S_RD_S : S_RS_A;
            end
            S_RD_S:  state_ff <= S_RD_D;
            S_RD_D: begin
               src_c_ff <= coef_rd_ff;
               src_f_ff <= flow_rd_ff;
               state_ff <= S_CAP_D;
            end
            S_CAP_D: begin
               dst_c_ff <= coef_rd_ff;
               dst_f_ff <= flow_rd_ff;
               state_ff <= S_KMUL;
            end
            S_KMUL: begin
               // 1 - r*r' in Q0.32
               k_ff     <= 33'h1_0000_0000 - 33'(32'(r_d_in) * 32'(r_s_in));
               t_ff     <= T_DST_ABS;
               state_ff <= S_P1;
            end
            S_P1: begin
               p1_ff    <= 40'(coef_in) * 40'(f_in);
               state_ff <= S_P2;
            end
            S_P2: begin
               num_ff   <= (t_ff == T_DST_ABS || t_ff == T_DST_FLOW) ? {p1_ff, 16'd0}
                         : 56'(p1_ff) * 56'(r_d_in);
               state_ff <= S_DIVS;
            end
            S_DIVS:  state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_done) begin
                  unique case (t_ff)
                     T_DST_ABS: begin
                        if (dir_ff) begin
                           dst_f_ff.abs_bot <= lrd_pkg::sat_add(dst_f_ff.abs_bot, div_q);
                        end else begin
                           dst_f_ff.abs_top <= lrd_pkg::sat_add(dst_f_ff.abs_top, div_q);
                        end
                     end
                     T_DST_FLOW: begin
                        if (dir_ff) begin
                           dst_f_ff.up <= lrd_pkg::sat_add(dst_f_ff.up, div_q);
                        end else begin
                           dst_f_ff.down <= lrd_pkg::sat_add(dst_f_ff.down, div_q);
                        end
                     end
                     T_SRC_ABS: begin
                        if (dir_ff) begin
                           src_f_ff.abs_top <= lrd_pkg::sat_add(src_f_ff.abs_top, div_q);
                        end else begin
                           src_f_ff.abs_bot <= lrd_pkg::sat_add(src_f_ff.abs_bot, div_q);
                        end
                     end
                     default: begin
                        if (dir_ff) begin
                           src_f_ff.down <= lrd_pkg::sat_add(src_f_ff.down, div_q);
                        end else begin
                           src_f_ff.up <= lrd_pkg::sat_add(src_f_ff.up, div_q);
                        end
                     end
                  endcase
                  t_ff     <= t_ff + 2'd1;
                  state_ff <= (t_ff == T_SRC_BACK) ? S_WR_S : S_P1;
               end
            end
            S_WR_S:  state_ff <= S_WR_D;
            S_WR_D: begin
               if (!dir_ff) begin
                  if (idx_p2_in < (CW+1)'(cnt_ff)) begin
                     idx_ff <= idx_ff + IW'(1);
                  end else begin
                     dir_ff <= 1'b1;
                     idx_ff <= IW'(cnt_ff - CW'(1));
                  end
                  state_ff <= S_RD_S;
               end else if (idx_ff > IW'(1)) begin
                  idx_ff   <= idx_ff - IW'(1);
                  state_ff <= S_RD_S;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= S_RS_A;
               end
            end
            S_RS_A:  state_ff <= S_RS_B;
            S_RS_B: begin
               res_ff <= res_ff + res_add_in;
               if (idx_p1_in == (CW+1)'(cnt_ff)) begin
                  state_ff <= S_CHK;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_RS_A;
               end
            end
            S_CHK: begin
               if (res_ff > RW'(residual_limit) && iter_ff < ITW'(MAX_SWEEPS)) begin
                  state_ff <= S_SWEEP;
               end else begin
                  state_ff <= S_FIN_A;
               end
            end
            S_FIN_A: state_ff <= S_FIN_B;
            S_FIN_B: begin
               // upward flow left at the sky lands on its bottom face
               src_f_ff <= '{abs_bot: lrd_pkg::sat_add(flow_rd_ff.abs_bot, flow_rd_ff.up),
                             abs_top: flow_rd_ff.abs_top, up: flow_rd_ff.up,
                             down: flow_rd_ff.down};
               state_ff <= S_FIN_W;
            end
            S_FIN_W: begin
               idx_ff   <= '0;
               state_ff <= S_OUT_A;
            end
            S_OUT_A: state_ff <= S_OUT_B;
            S_OUT_B: begin
               if (out_ready) begin
                  if (idx_p1_in == (CW+1)'(cnt_ff)) begin
                     cnt_ff   <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     idx_ff   <= idx_ff + IW'(1);
                     state_ff <= S_OUT_A;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign out_valid = state_ff == S_OUT_B;
   always_comb begin
      out_item.layer_number    = 4'(idx_ff);
      out_item.absorbed_top    = flow_rd_ff.abs_top;
      out_item.absorbed_bottom = flow_rd_ff.abs_bot;
      out_item.iterations_used = 7'(iter_ff);
      out_item.not_converged   = iter_ff == ITW'(MAX_SWEEPS);
      out_item.last_result     = idx_p1_in == (CW+1)'(cnt_ff);
   end

endmodule

// ===== design/layered_radiation_distributor.sv =====
// Layers stream in top (sky) first, one item per cycle, until an item with tlast set;
// that item starts the solve and req_tready stays low until the last result has moved
// into the output register. All layer state sits in two synchronous RAMs (one read and
// one write port each); each neighbor transfer reads
// both rows, forms four terms in turn through one shared bit-serial divider and writes
// both rows back. One sweep pair over n layers costs about 2(n-1) transfers plus a
// residual pass over all n rows, and up to MAX_SWEEPS pairs run. Results then leave
// one layer at a time, top first.
module layered_radiation_distributor #(
   parameter int MAX_LAYERS = 16,
   parameter int MAX_SWEEPS = 99
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // abs_top, abs_bottom, refl_top, refl_bottom, trans_top, trans_bottom, emit_down, emit_up
   input  logic [143:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // layer_number, absorbed_top, absorbed_bottom, iterations_used, not_converged, zero pad
   output logic [63:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [23:0]  csr_wdata
);

   logic [23:0]          limit_ff;
   logic                 rsp_valid_ff;
   lrd_pkg::result_type  rsp_ff;
   lrd_pkg::layer_in_type in_item;
   lrd_pkg::result_type  core_item;
   logic                 core_valid;
   logic                 core_ready;

   always_comb begin
      in_item.coef.top_a  = req_tdata[15:0];
      in_item.coef.bot_a  = req_tdata[31:16];
      in_item.coef.top_r  = req_tdata[47:32];
      in_item.coef.bot_r  = req_tdata[63:48];
      in_item.coef.top_t  = req_tdata[79:64];
      in_item.coef.bot_t  = req_tdata[95:80];
      in_item.emit_down   = req_tdata[119:96];
      in_item.emit_up     = req_tdata[143:120];
      in_item.last_layer  = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lrd_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   lrd_core #(
      .MAX_LAYERS (MAX_LAYERS),
      .MAX_SWEEPS (MAX_SWEEPS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_item        (in_item),
      .residual_limit (limit_ff),
      .out_valid      (core_valid),
      .out_ready      (core_ready),
      .out_item       (core_item)
   );

   assign core_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_ready) begin
         rsp_valid_ff <= core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (core_ready && core_valid) begin
         rsp_ff <= core_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.not_converged, rsp_ff.iterations_used,
                        rsp_ff.absorbed_bottom, rsp_ff.absorbed_top, rsp_ff.layer_number};
   assign rsp_tlast  = rsp_ff.last_result;

endmodule

// ===== tb/layered_radiation_distributor_tb.sv =====
module layered_radiation_distributor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_LAYERS = 16;
   localparam int NUM_SWEEPS = 99;
   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int IDLE_PCT = 13;

   // Expected absorbed sums per layer, worked out when the bottom layer arrives.
   class radiation_scoreboard;
      logic [23:0]                limit;
      lrd_pkg::coef_row_type      coef[NUM_LAYERS];
      logic [lrd_pkg::FLOW_W-1:0] down[NUM_LAYERS];
      logic [lrd_pkg::FLOW_W-1:0] up[NUM_LAYERS];
      logic [lrd_pkg::FLOW_W-1:0] abs_top[NUM_LAYERS];
      logic [lrd_pkg::FLOW_W-1:0] abs_bot[NUM_LAYERS];
      int                         loaded;
      lrd_pkg::result_type        expected_q[$];
      int                         errors;
      int                         solves;
      int                         unconverged;
      int                         checked;

      function new();
         limit = lrd_pkg::LIMIT_RESET;
         loaded = 0;
         errors = 0;
         solves = 0;
         unconverged = 0;
         checked = 0;
      endfunction

      function void set_limit(logic [23:0] v);
         limit = v;
      endfunction

      function logic [23:0] add24(logic [23:0] a, logic [23:0] b);
         logic [24:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[24] ? lrd_pkg::FLOW_MAX : s[23:0];
      endfunction

      function logic [23:0] quotient(logic [63:0] num, logic [63:0] k);
         logic [63:0] q;
         if (k == 0) begin
            return (num != 0) ? lrd_pkg::FLOW_MAX : 24'd0;
         end
         q = num / k;
         return (q > 64'hFFFFFF) ? lrd_pkg::FLOW_MAX : q[23:0];
      endfunction

      function logic [23:0] direct(logic [15:0] c, logic [23:0] f, logic [63:0] k);
         logic [63:0] num;
         num = (64'(c) * 64'(f)) << 16;
         return quotient(num, k);
      endfunction

      function logic [23:0] reflected(logic [15:0] c, logic [15:0] r, logic [23:0] f,
                                      logic [63:0] k);
         return quotient(64'(c) * 64'(r) * 64'(f), k);
      endfunction

      function void pass_down(int n);
         logic [63:0] k;
         logic [23:0] f;
         for (int i = 0; i + 1 < n; i++) begin
            f = down[i];
            k = (64'd1 << 32) - 64'(coef[i+1].top_r) * 64'(coef[i].bot_r);
            abs_top[i+1] = add24(abs_top[i+1], direct(coef[i+1].top_a, f, k));
            down[i+1] = add24(down[i+1], direct(coef[i+1].top_t, f, k));
            abs_bot[i] = add24(abs_bot[i], reflected(coef[i].bot_a, coef[i+1].top_r, f, k));
            up[i] = add24(up[i], reflected(coef[i].bot_t, coef[i+1].top_r, f, k));
            down[i] = '0;
         end
      endfunction

      function void pass_up(int n);
         logic [63:0] k;
         logic [23:0] f;
         for (int i = n - 1; i > 0; i--) begin
            f = up[i];
            k = (64'd1 << 32) - 64'(coef[i-1].bot_r) * 64'(coef[i].top_r);
            abs_bot[i-1] = add24(abs_bot[i-1], direct(coef[i-1].bot_a, f, k));
            up[i-1] = add24(up[i-1], direct(coef[i-1].bot_t, f, k));
            abs_top[i] = add24(abs_top[i], reflected(coef[i].top_a, coef[i-1].bot_r, f, k));
            down[i] = add24(down[i], reflected(coef[i].top_t, coef[i-1].bot_r, f, k));
            up[i] = '0;
         end
      endfunction

      function void run_solve();
         int n;
         int iter;
         logic [63:0] residual;
         lrd_pkg::result_type res;
         n = loaded;
         for (int i = 0; i < n; i++) begin
            abs_top[i] = '0;
            abs_bot[i] = '0;
         end
         iter = 0;
         do begin
            iter++;
            pass_down(n);
            pass_up(n);
            residual = 64'(down[0]);
            for (int i = 1; i < n; i++)
               residual += 64'(down[i]) + 64'(up[i]);
         end while (residual > 64'(limit) && iter < NUM_SWEEPS);
         abs_bot[0] = add24(abs_bot[0], up[0]);
         for (int i = 0; i < n; i++) begin
            res.layer_number = i[3:0];
            res.absorbed_top = abs_top[i];
            res.absorbed_bottom = abs_bot[i];
            res.iterations_used = iter[6:0];
            res.not_converged = (iter == NUM_SWEEPS);
            res.last_result = (i == n - 1);
            expected_q.push_back(res);
         end
         solves++;
         if (iter == NUM_SWEEPS)
            unconverged++;
         loaded = 0;
      endfunction

      function void note_layer(lrd_pkg::layer_in_type l);
         if (loaded < NUM_LAYERS) begin
            coef[loaded] = l.coef;
            down[loaded] = l.emit_down;
            up[loaded] = l.emit_up;
            loaded++;
         end
         if (l.last_layer)
            run_solve();
      endfunction

      function void check_result(lrd_pkg::result_type got);
         lrd_pkg::result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            $error("result item with nothing expected: %p", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.layer_number !== want.layer_number) begin
            $error("layer_number: expected %0d, got %0d", want.layer_number, got.layer_number);
            errors++;
         end
         if (got.absorbed_top !== want.absorbed_top) begin
            $error("absorbed_top: expected %h, got %h", want.absorbed_top, got.absorbed_top);
            errors++;
         end
         if (got.absorbed_bottom !== want.absorbed_bottom) begin
            $error("absorbed_bottom: expected %h, got %h",
                   want.absorbed_bottom, got.absorbed_bottom);
            errors++;
         end
         if (got.iterations_used !== want.iterations_used) begin
            $error("iterations_used: expected %0d, got %0d",
                   want.iterations_used, got.iterations_used);
            errors++;
         end
         if (got.not_converged !== want.not_converged) begin
            $error("not_converged: expected %0b, got %0b",
                   want.not_converged, got.not_converged);
            errors++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we;
   logic [23:0]  csr_wdata;

   radiation_scoreboard sb;
   bit          quiet;
   int          layers_sent;
   int          stall_cycles;
   logic [23:0] cur_limit;

   layered_radiation_distributor #(
      .MAX_LAYERS(NUM_LAYERS),
      .MAX_SWEEPS(NUM_SWEEPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: random stalls, check every accepted item
   always @(posedge clock) begin
      lrd_pkg::result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.layer_number = rsp_tdata[3:0];
            got.absorbed_top = rsp_tdata[27:4];
            got.absorbed_bottom = rsp_tdata[51:28];
            got.iterations_used = rsp_tdata[58:52];
            got.not_converged = rsp_tdata[59];
            got.last_result = rsp_tlast;
            sb.check_result(got);
         end
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_layer(lrd_pkg::layer_in_type l);
      if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {l.emit_up, l.emit_down, l.coef.bot_t, l.coef.top_t,
                    l.coef.bot_r, l.coef.top_r, l.coef.bot_a, l.coef.top_a};
      req_tlast <= l.last_layer;
      do @(posedge clock); while (!req_tready);
      sb.note_layer(l);
      layers_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_limit(logic [23:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_limit(v);
      cur_limit = v;
   endtask

   // Well-formed layers keep transfers shrinking and give the ground a top face with no
   // transmissivity, so the solve settles; a noisy layer is fully random.
   function automatic lrd_pkg::layer_in_type make_layer(bit bottom, bit noisy);
      lrd_pkg::layer_in_type l;
      l.coef.top_a = 16'($urandom_range(0, 16'hFFFF));
      l.coef.bot_a = 16'($urandom_range(0, 16'hFFFF));
      l.emit_up = 24'($urandom_range(0, 24'hFFFFFF));
      l.emit_down = 24'($urandom_range(0, 24'hFFFFFF));
      l.last_layer = bottom;
      if (noisy) begin
         l.coef.top_r = 16'($urandom_range(0, 16'hFFFF));
         l.coef.bot_r = 16'($urandom_range(0, 16'hFFFF));
         l.coef.top_t = 16'($urandom_range(0, 16'hFFFF));
         l.coef.bot_t = 16'($urandom_range(0, 16'hFFFF));
      end else begin
         l.coef.top_r = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                    : 16'($urandom_range(0, 16'h7FFF));
         l.coef.bot_r = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                    : 16'($urandom_range(0, 16'h7FFF));
         l.coef.top_t = 16'($urandom_range(0, 16'h3FFF));
         l.coef.bot_t = 16'($urandom_range(0, 16'h3FFF));
         if (bottom) begin
            l.coef.top_t = '0;
            l.emit_down = 24'($urandom_range(0, cur_limit / 4));
         end
      end
      return l;
   endfunction

   task automatic random_phase(logic [23:0] lim, int num_items);
      int target;
      int n;
      bit noisy;
      write_limit(lim);
      target = layers_sent + num_items;
      while (layers_sent < target) begin
         noisy = ($urandom_range(0, 9) == 0);
         n = noisy ? $urandom_range(1, 2) : $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            send_layer(make_layer(i == n - 1, noisy));
      end
   endtask

   initial begin
      lrd_pkg::layer_in_type l;
      sb = new();
      quiet = 1'b0;
      layers_sent = 0;
      cur_limit = lrd_pkg::LIMIT_RESET;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single layer at full scale: nothing moves, residual stays above the limit
      l = '1;
      send_layer(l);
      // single layer, all zero: settles on the first pass
      l = '0;
      l.last_layer = 1'b1;
      send_layer(l);
      // sky over ground
      send_layer(make_layer(1'b0, 1'b0));
      send_layer(make_layer(1'b1, 1'b0));
      // a full stack with no emission, then two extra layers that must be dropped
      for (int i = 0; i < NUM_LAYERS + 2; i++) begin
         l = make_layer(1'b0, 1'b1);
         if (i < NUM_LAYERS) begin
            l.emit_down = '0;
            l.emit_up = '0;
         end
         l.last_layer = (i == NUM_LAYERS + 1);
         send_layer(l);
      end

      random_phase(24'hFFFFFF, 70);
      quiet <= 1'b1;
      random_phase(24'($urandom_range(24'h800, 24'h20000)), 60);
      quiet <= 1'b0;
      random_phase(24'($urandom_range(24'h800, 24'h20000)), 60);
      random_phase(lrd_pkg::LIMIT_RESET, 80);

      // zero limit: only a stack with every flow gone settles
      write_limit(24'd0);
      for (int r = 0; r < 5; r++) begin
         l = make_layer(1'b1, 1'b0);
         if (r[0]) begin
            l.emit_down = '0;
         end
         send_layer(l);
      end

      drain();
      $display("Covered %0d layer items in %0d solves, %0d of them hitting the sweep cap.",
               layers_sent, sb.solves, sb.unconverged);
      $display("Checked %0d result items against the predicted absorbed sums.", sb.checked);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
